FILE: src/croa_pkg.sv
// croa_pkg: shared types, widths and the arctangent table for the
// circle/box overlap area block. No dependencies.
package croa_pkg;

    // fixed field widths (Q16.16 coordinates, Q32.32 area)
    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int AREA_W   = 64;

    // internal widths
    localparam int DIFF_W   = COORD_W + 1;      // centre-relative coordinate
    localparam int HGT_W    = COORD_W;          // non-negative strip height
    localparam int R2_W     = 2 * RADIUS_W;     // radius squared
    localparam int PROD_W   = 2 * COORD_W;      // shared multiplier product
    localparam int ACC_W    = AREA_W + 2;       // segment accumulator
    localparam int SEG_W    = AREA_W + 1;       // doubled segment integral
    localparam int REM_W    = RADIUS_W + 4;     // square root remainder
    localparam int CD_W     = 49;               // cordic vector components
    localparam int ANG_W    = 32;               // cordic angle, signed
    localparam int NORM_BIT = 45;               // prescale target bit
    localparam int ANG_FRAC = 30;               // angle scale 2^30
    localparam int CD_STEPS = 31;
    localparam int SQ_STEPS = RADIUS_W;
    localparam int STEP_W   = 5;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,        // capture input transfer
        OP_PREP,        // sort edges, form strip heights
        OP_MUL_RR,
        OP_SET_R2,
        OP_SEL_H,
        OP_MUL_HH,
        OP_SQ_LOAD,
        OP_SQ_STEP,
        OP_CLAMP,
        OP_MODE,
        OP_SEL_M,
        OP_MUL_MM,
        OP_CD_LOAD,
        OP_CD_NORM,
        OP_CD_STEP,
        OP_MUL_MQ,
        OP_T1,
        OP_T2,
        OP_T3,
        OP_T4,
        OP_G_ZERO,
        OP_STRIP,
        OP_STRIP_ZERO,
        OP_BOX,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [1:0]          idx;
        logic [STEP_W-1:0]   step;
    } dp_cmd_t;

    typedef struct packed {
        logic h_ge_r;
        logic m_zero;
        logic norm_done;
        logic two_boxes;
    } dp_stat_t;

    // atan(2^-i) scaled by 2^30, rounded to nearest
    function automatic logic [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [ANG_W-1:0] v;
        unique case (i)
            5'd0:  v = 32'd843314857;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043837;
            5'd3:  v = 32'd133525159;
            5'd4:  v = 32'd67021687;
            5'd5:  v = 32'd33543516;
            5'd6:  v = 32'd16775851;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194283;
            5'd9:  v = 32'd2097149;
            default: v = 32'd1 << (5'd30 - i);
        endcase
        return v;
    endfunction

endpackage

FILE: src/croa_dp.sv
// croa_dp: datapath of the overlap area block - operand registers, shared
// multiplier, digit square root, vectoring cordic and accumulators.
// Depends on croa_pkg.
module croa_dp (
    input  logic                               aclk,
    input  croa_pkg::dp_cmd_t                  cmd,
    input  logic signed [croa_pkg::COORD_W-1:0] left_edge,
    input  logic signed [croa_pkg::COORD_W-1:0] right_edge,
    input  logic signed [croa_pkg::COORD_W-1:0] bottom_edge,
    input  logic signed [croa_pkg::COORD_W-1:0] top_edge,
    input  logic signed [croa_pkg::COORD_W-1:0] centre_x,
    input  logic signed [croa_pkg::COORD_W-1:0] centre_y,
    input  logic [croa_pkg::RADIUS_W-1:0]      radius,
    output croa_pkg::dp_stat_t                 stat,
    output logic [croa_pkg::AREA_W-1:0]        area_out
);

    localparam int DW = croa_pkg::DIFF_W;
    localparam int RW = croa_pkg::RADIUS_W;
    localparam int HW = croa_pkg::HGT_W;
    localparam int PW = croa_pkg::PROD_W;
    localparam int AW = croa_pkg::ACC_W;
    localparam int GW = croa_pkg::SEG_W;
    localparam int OW = croa_pkg::AREA_W;
    localparam int CW = croa_pkg::CD_W;
    localparam int ZW = croa_pkg::ANG_W;
    localparam int QW = croa_pkg::REM_W;
    localparam int VW = croa_pkg::R2_W;
    localparam int COORD_MSB = croa_pkg::COORD_W - 1;
    localparam int NORM_LO8  = croa_pkg::NORM_BIT - 8;

    logic signed [DW-1:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [RW-1:0]        r_reg;
    logic [VW-1:0]        r2_reg;
    logic [HW-1:0]        hgt_reg [4];
    logic                 two_reg;
    logic [HW-1:0]        h_reg;
    logic [PW-1:0]        prod_reg;
    logic [VW-1:0]        sq_val_reg;
    logic [QW-1:0]        sq_rem_reg;
    logic [RW-1:0]        root_reg;
    logic signed [DW-1:0] ac_reg, bc_reg;
    logic [RW-1:0]        m1_reg, m2_reg, m_reg;
    logic                 add_reg;
    logic signed [CW-1:0] vx_reg, vy_reg;
    logic signed [ZW-1:0] z_reg;
    logic [AW-1:0]        acc_reg;
    logic [GW-1:0]        g_reg [2];
    logic [OW-1:0]        st_reg [2];
    logic [OW:0]          area_reg;
    logic [OW-1:0]        out_reg;

    // shared multiplier operand selection
    logic [HW-1:0] mul_a, mul_b;
    logic          mul_en;
    logic [RW-1:0] ang;

    assign ang = z_reg[ZW-1] ? '0 : z_reg[RW-1:0];

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (cmd.op)
            croa_pkg::OP_MUL_RR: begin mul_a = HW'(r_reg);  mul_b = HW'(r_reg); end
            croa_pkg::OP_MUL_HH: begin mul_a = h_reg;       mul_b = h_reg; end
            croa_pkg::OP_MUL_MM: begin mul_a = HW'(m_reg);  mul_b = HW'(m_reg); end
            croa_pkg::OP_MUL_MQ: begin mul_a = HW'(m_reg);  mul_b = HW'(root_reg); end
            croa_pkg::OP_T1: begin mul_a = HW'(r2_reg[RW-1:0]);  mul_b = HW'(ang); end
            croa_pkg::OP_T2: begin mul_a = HW'(r2_reg[VW-1:RW]); mul_b = HW'(ang); end
            croa_pkg::OP_T3: begin mul_a = h_reg;       mul_b = HW'(m_reg); end
            default: mul_en = 1'b0;
        endcase
    end

    // edge sorting and strip heights
    logic signed [DW-1:0] xlo, xhi, ylo, yhi, neg_ylo, neg_yhi;
    logic [HW-1:0]        hg [4];
    logic                 two_next;

    always_comb begin
        xlo = (x0_reg > x1_reg) ? x1_reg : x0_reg;
        xhi = (x0_reg > x1_reg) ? x0_reg : x1_reg;
        ylo = (y0_reg > y1_reg) ? y1_reg : y0_reg;
        yhi = (y0_reg > y1_reg) ? y0_reg : y1_reg;
        neg_ylo = -ylo;
        neg_yhi = -yhi;
        hg[0] = '0;
        hg[1] = '0;
        hg[2] = '0;
        hg[3] = '0;
        two_next = 1'b0;
        if (yhi < 0) begin
            hg[0] = neg_yhi[HW-1:0];
            hg[1] = neg_ylo[HW-1:0];
        end else if (ylo < 0) begin
            hg[1] = neg_ylo[HW-1:0];
            hg[3] = yhi[HW-1:0];
            two_next = 1'b1;
        end else begin
            hg[0] = ylo[HW-1:0];
            hg[1] = yhi[HW-1:0];
        end
    end

    // clamp to the chord half-width and pick segment arguments
    logic signed [DW-1:0] s_pos, s_neg, ac_next, bc_next, neg_ac, neg_bc;

    always_comb begin
        s_pos = $signed({2'b00, root_reg});
        s_neg = -s_pos;
        ac_next = (x0_reg < s_neg) ? s_neg : (x0_reg > s_pos) ? s_pos : x0_reg;
        bc_next = (x1_reg < s_neg) ? s_neg : (x1_reg > s_pos) ? s_pos : x1_reg;
        neg_ac = -ac_reg;
        neg_bc = -bc_reg;
    end

    // square root digit step
    logic [QW-1:0] rem_sh, trial;
    assign rem_sh = {sq_rem_reg[QW-3:0], sq_val_reg[VW-1:VW-2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    // cordic micro-rotation
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] tab;
    logic [CW-1:0]        vor;
    assign dx  = vy_reg >>> cmd.step;
    assign dy  = vx_reg >>> cmd.step;
    assign tab = $signed(croa_pkg::atan_entry(cmd.step));
    assign vor = vx_reg | vy_reg;

    // segment and strip arithmetic
    logic [AW-1:0] hm2, gsum, gdiff;
    assign hm2   = {1'b0, prod_reg, 1'b0};
    assign gsum  = AW'(g_reg[0]) + AW'(g_reg[1]);
    assign gdiff = (g_reg[0] >= g_reg[1]) ? AW'(g_reg[0] - g_reg[1]) : '0;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        unique case (cmd.op)
            croa_pkg::OP_LOAD: begin
                x0_reg <= $signed({left_edge[COORD_MSB], left_edge})
                        - $signed({centre_x[COORD_MSB], centre_x});
                x1_reg <= $signed({right_edge[COORD_MSB], right_edge})
                        - $signed({centre_x[COORD_MSB], centre_x});
                y0_reg <= $signed({bottom_edge[COORD_MSB], bottom_edge})
                        - $signed({centre_y[COORD_MSB], centre_y});
                y1_reg <= $signed({top_edge[COORD_MSB], top_edge})
                        - $signed({centre_y[COORD_MSB], centre_y});
                r_reg  <= radius;
            end
            croa_pkg::OP_PREP: begin
                x0_reg   <= xlo;
                x1_reg   <= xhi;
                hgt_reg  <= hg;
                two_reg  <= two_next;
                area_reg <= '0;
            end
            croa_pkg::OP_SET_R2: r2_reg <= prod_reg[VW-1:0];
            croa_pkg::OP_SEL_H:  h_reg  <= hgt_reg[cmd.idx];
            croa_pkg::OP_SQ_LOAD: begin
                sq_val_reg <= (prod_reg[PW-1:VW] == '0 && r2_reg >= prod_reg[VW-1:0])
                            ? r2_reg - prod_reg[VW-1:0] : '0;
                sq_rem_reg <= '0;
                root_reg   <= '0;
            end
            croa_pkg::OP_SQ_STEP: begin
                sq_val_reg <= {sq_val_reg[VW-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    sq_rem_reg <= rem_sh - trial;
                    root_reg   <= {root_reg[RW-2:0], 1'b1};
                end else begin
                    sq_rem_reg <= rem_sh;
                    root_reg   <= {root_reg[RW-2:0], 1'b0};
                end
            end
            croa_pkg::OP_CLAMP: begin
                ac_reg <= ac_next;
                bc_reg <= bc_next;
            end
            croa_pkg::OP_MODE: begin
                if (ac_reg >= 0) begin
                    m1_reg <= bc_reg[RW-1:0];
                    m2_reg <= ac_reg[RW-1:0];
                    add_reg <= 1'b0;
                end else if (bc_reg <= 0) begin
                    m1_reg <= neg_ac[RW-1:0];
                    m2_reg <= neg_bc[RW-1:0];
                    add_reg <= 1'b0;
                end else begin
                    m1_reg <= bc_reg[RW-1:0];
                    m2_reg <= neg_ac[RW-1:0];
                    add_reg <= 1'b1;
                end
            end
            croa_pkg::OP_SEL_M: m_reg <= cmd.idx[0] ? m2_reg : m1_reg;
            croa_pkg::OP_CD_LOAD: begin
                vx_reg <= $signed(CW'(root_reg));
                vy_reg <= $signed(CW'(m_reg));
                z_reg  <= '0;
            end
            croa_pkg::OP_CD_NORM: begin
                if (vor[CW-1:NORM_LO8] == '0) begin
                    vx_reg <= vx_reg <<< 8;
                    vy_reg <= vy_reg <<< 8;
                end else if (vor[CW-1:croa_pkg::NORM_BIT] == '0) begin
                    vx_reg <= vx_reg <<< 1;
                    vy_reg <= vy_reg <<< 1;
                end
            end
            croa_pkg::OP_CD_STEP: begin
                if (vy_reg >= 0) begin
                    vx_reg <= vx_reg + dx;
                    vy_reg <= vy_reg - dy;
                    z_reg  <= z_reg + tab;
                end else begin
                    vx_reg <= vx_reg - dx;
                    vy_reg <= vy_reg + dy;
                    z_reg  <= z_reg - tab;
                end
            end
            croa_pkg::OP_T1: acc_reg <= AW'(prod_reg);
            croa_pkg::OP_T2: acc_reg <= acc_reg + AW'(prod_reg >> croa_pkg::ANG_FRAC);
            croa_pkg::OP_T3: acc_reg <= acc_reg + {1'b0, prod_reg, 1'b0};
            croa_pkg::OP_T4: g_reg[cmd.idx[0]] <= (acc_reg >= hm2)
                                                ? GW'(acc_reg - hm2) : '0;
            croa_pkg::OP_G_ZERO: g_reg[cmd.idx[0]] <= '0;
            croa_pkg::OP_STRIP:
                st_reg[cmd.idx[0]] <= add_reg ? gsum[OW:1] : gdiff[OW:1];
            croa_pkg::OP_STRIP_ZERO: st_reg[cmd.idx[0]] <= '0;
            croa_pkg::OP_BOX:
                area_reg <= area_reg + ((st_reg[0] >= st_reg[1])
                            ? (OW+1)'(st_reg[0] - st_reg[1]) : '0);
            croa_pkg::OP_OUT: out_reg <= area_reg[OW] ? '1 : area_reg[OW-1:0];
            default: ;
        endcase
    end

    assign stat.h_ge_r    = (h_reg >= HW'(r_reg));
    assign stat.m_zero    = (m_reg == '0);
    assign stat.norm_done = (vor[CW-1:croa_pkg::NORM_BIT] != '0);
    assign stat.two_boxes = two_reg;
    assign area_out       = out_reg;

endmodule

FILE: src/croa_ctrl.sv
// croa_ctrl: sequencer of the overlap area block - walks boxes, strips and
// segment integrals and issues datapath commands. Depends on croa_pkg.
module croa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  croa_pkg::dp_stat_t stat,
    output croa_pkg::dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_RR, S_R2, S_SEL_H, S_CHK_H, S_STRIP_Z, S_HH,
        S_SQL_S, S_SQS_S, S_CLAMP, S_MODE, S_SEL_M, S_CHK_M, S_G_ZERO,
        S_MM, S_SQL_M, S_SQS_M, S_CDL, S_CDN, S_CDS, S_MQ, S_T1, S_T2,
        S_T3, S_T4, S_STRIP, S_BOX, S_OUT
    } state_t;

    state_t state_reg;
    logic [croa_pkg::STEP_W-1:0] cnt_reg;
    logic box_reg, strip_reg, seg_reg, m_valid_reg;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    // command decode
    always_comb begin
        cmd.op   = croa_pkg::OP_NOP;
        cmd.idx  = {1'b0, seg_reg};
        cmd.step = cnt_reg;
        unique case (state_reg)
            S_IDLE:    if (s_valid) cmd.op = croa_pkg::OP_LOAD;
            S_PREP:    cmd.op = croa_pkg::OP_PREP;
            S_RR:      cmd.op = croa_pkg::OP_MUL_RR;
            S_R2:      cmd.op = croa_pkg::OP_SET_R2;
            S_SEL_H: begin
                cmd.op  = croa_pkg::OP_SEL_H;
                cmd.idx = {box_reg, strip_reg};
            end
            S_CHK_H:   cmd.op = croa_pkg::OP_NOP;
            S_STRIP_Z: begin
                cmd.op  = croa_pkg::OP_STRIP_ZERO;
                cmd.idx = {1'b0, strip_reg};
            end
            S_HH:      cmd.op = croa_pkg::OP_MUL_HH;
            S_SQL_S, S_SQL_M: cmd.op = croa_pkg::OP_SQ_LOAD;
            S_SQS_S, S_SQS_M: cmd.op = croa_pkg::OP_SQ_STEP;
            S_CLAMP:   cmd.op = croa_pkg::OP_CLAMP;
            S_MODE:    cmd.op = croa_pkg::OP_MODE;
            S_SEL_M:   cmd.op = croa_pkg::OP_SEL_M;
            S_CHK_M:   cmd.op = croa_pkg::OP_NOP;
            S_G_ZERO:  cmd.op = croa_pkg::OP_G_ZERO;
            S_MM:      cmd.op = croa_pkg::OP_MUL_MM;
            S_CDL:     cmd.op = croa_pkg::OP_CD_LOAD;
            S_CDN:     cmd.op = croa_pkg::OP_CD_NORM;
            S_CDS:     cmd.op = croa_pkg::OP_CD_STEP;
            S_MQ:      cmd.op = croa_pkg::OP_MUL_MQ;
            S_T1:      cmd.op = croa_pkg::OP_T1;
            S_T2:      cmd.op = croa_pkg::OP_T2;
            S_T3:      cmd.op = croa_pkg::OP_T3;
            S_T4:      cmd.op = croa_pkg::OP_T4;
            S_STRIP: begin
                cmd.op  = croa_pkg::OP_STRIP;
                cmd.idx = {1'b0, strip_reg};
            end
            S_BOX:     cmd.op = croa_pkg::OP_BOX;
            S_OUT:     if (out_free) cmd.op = croa_pkg::OP_OUT;
            default:   cmd.op = croa_pkg::OP_NOP;
        endcase
    end

    // sequencer and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            box_reg     <= 1'b0;
            strip_reg   <= 1'b0;
            seg_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // result valid: set when a result is loaded, cleared on its transfer
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: if (s_valid) state_reg <= S_PREP;
                S_PREP: state_reg <= S_RR;
                S_RR:   state_reg <= S_R2;
                S_R2: begin
                    box_reg   <= 1'b0;
                    strip_reg <= 1'b0;
                    state_reg <= S_SEL_H;
                end
                S_SEL_H: state_reg <= S_CHK_H;
                S_CHK_H: state_reg <= stat.h_ge_r ? S_STRIP_Z : S_HH;
                S_HH:    state_reg <= S_SQL_S;
                S_SQL_S: begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQS_S;
                end
                S_SQS_S: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == croa_pkg::STEP_W'(croa_pkg::SQ_STEPS - 1)) begin
                        state_reg <= S_CLAMP;
                    end
                end
                S_CLAMP: state_reg <= S_MODE;
                S_MODE: begin
                    seg_reg   <= 1'b0;
                    state_reg <= S_SEL_M;
                end
                S_SEL_M:  state_reg <= S_CHK_M;
                S_CHK_M:  state_reg <= stat.m_zero ? S_G_ZERO : S_MM;
                S_MM:     state_reg <= S_SQL_M;
                S_SQL_M: begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQS_M;
                end
                S_SQS_M: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == croa_pkg::STEP_W'(croa_pkg::SQ_STEPS - 1)) begin
                        state_reg <= S_CDL;
                    end
                end
                S_CDL: state_reg <= S_CDN;
                S_CDN: begin
                    cnt_reg <= '0;
                    if (stat.norm_done) begin
                        state_reg <= S_CDS;
                    end
                end
                S_CDS: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == croa_pkg::STEP_W'(croa_pkg::CD_STEPS - 1)) begin
                        state_reg <= S_MQ;
                    end
                end
                S_MQ: state_reg <= S_T1;
                S_T1: state_reg <= S_T2;
                S_T2: state_reg <= S_T3;
                S_T3: state_reg <= S_T4;
                S_T4, S_G_ZERO: begin
                    if (!seg_reg) begin
                        seg_reg   <= 1'b1;
                        state_reg <= S_SEL_M;
                    end else begin
                        state_reg <= S_STRIP;
                    end
                end
                S_STRIP, S_STRIP_Z: begin
                    if (!strip_reg) begin
                        strip_reg <= 1'b1;
                        state_reg <= S_SEL_H;
                    end else begin
                        state_reg <= S_BOX;
                    end
                end
                S_BOX: begin
                    if (!box_reg && stat.two_boxes) begin
                        box_reg   <= 1'b1;
                        strip_reg <= 1'b0;
                        state_reg <= S_SEL_H;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: src/circle_rect_overlap_area.sv
// circle_rect_overlap_area: top level - area of an axis-aligned box inside
// a circle. Depends on croa_pkg, croa_ctrl and croa_dp.
//
//  channel | direction | handshake        | payload
//  s_      | in        | s_valid/s_ready  | box edges, centre, radius (Q16.16)
//  m_      | out       | m_valid/m_ready  | m_overlap_area (Q32.32, saturating)
//
// One item at a time; setup captures the input, sorts the edges and squares
// the radius. A strip at or above the radius is set to zero, otherwise the
// square root of the chord (31 digit steps) is followed by two segment
// integrals, each zero for a zero argument or else a 31-step square root, a
// prescale and 31 cordic steps; a box spanning the centre line has four
// strips. The result sits in an output register, so the next item is taken
// while it waits. Reset is synchronous on aresetn and clears control.
module circle_rect_overlap_area (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [croa_pkg::COORD_W-1:0] s_left_edge,
    input  logic signed [croa_pkg::COORD_W-1:0] s_right_edge,
    input  logic signed [croa_pkg::COORD_W-1:0] s_bottom_edge,
    input  logic signed [croa_pkg::COORD_W-1:0] s_top_edge,
    input  logic signed [croa_pkg::COORD_W-1:0] s_centre_x,
    input  logic signed [croa_pkg::COORD_W-1:0] s_centre_y,
    input  logic [croa_pkg::RADIUS_W-1:0]       s_radius,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [croa_pkg::AREA_W-1:0]         m_overlap_area
);

    croa_pkg::dp_cmd_t  cmd;
    croa_pkg::dp_stat_t stat;

    // sequencer
    croa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic
    croa_dp u_dp (
        .aclk        (aclk),
        .cmd         (cmd),
        .left_edge   (s_left_edge),
        .right_edge  (s_right_edge),
        .bottom_edge (s_bottom_edge),
        .top_edge    (s_top_edge),
        .centre_x    (s_centre_x),
        .centre_y    (s_centre_y),
        .radius      (s_radius),
        .stat        (stat),
        .area_out    (m_overlap_area)
    );

endmodule

FILE: tb/sv/tb_circle_rect_overlap_area.sv
// tb_circle_rect_overlap_area: self-checking bench for the circle/box overlap
// area block. Depends on croa_pkg and circle_rect_overlap_area.
module tb_circle_rect_overlap_area;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [127:0] wide_t;

    typedef struct {
        logic signed [croa_pkg::COORD_W-1:0] x_a;
        logic signed [croa_pkg::COORD_W-1:0] x_b;
        logic signed [croa_pkg::COORD_W-1:0] y_a;
        logic signed [croa_pkg::COORD_W-1:0] y_b;
        logic signed [croa_pkg::COORD_W-1:0] cx;
        logic signed [croa_pkg::COORD_W-1:0] cy;
        logic [croa_pkg::RADIUS_W-1:0]       rad;
    } box_item_t;

    // area scoreboard: predicts the overlap area and checks results in order
    class area_scoreboard;
        logic [croa_pkg::AREA_W-1:0] pending_area[$];
        int                          errors;

        function new();
            errors = 0;
        endfunction

        function wide_t sub_floor0(wide_t a, wide_t b);
            return (a < b) ? '0 : a - b;
        endfunction

        function longint unsigned isqrt(wide_t v);
            longint unsigned res;
            longint unsigned t;
            res = 0;
            for (int bit_i = 63; bit_i >= 0; bit_i--) begin
                t = res | (64'd1 << bit_i);
                if (wide_t'(t) * wide_t'(t) <= v) res = t;
            end
            return res;
        endfunction

        function longint atan_step(int i);
            case (i)
                0: return 843314857;
                1: return 497837829;
                2: return 263043837;
                3: return 133525159;
                4: return 67021687;
                5: return 33543516;
                6: return 16775851;
                7: return 8388437;
                8: return 4194283;
                9: return 2097149;
                default: return 64'sd1 << (30 - i);
            endcase
        endfunction

        // vectoring rotation, angle of (x, y) scaled by 2^30
        function longint unsigned angle_of(longint unsigned y, longint unsigned x);
            longint vx, vy, z, dx, dy;
            vx = x;
            vy = y;
            z  = 0;
            while ((vx | vy) < (64'sd1 << croa_pkg::NORM_BIT)) begin
                vx = vx * 2;
                vy = vy * 2;
            end
            for (int i = 0; i < croa_pkg::CD_STEPS; i++) begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (vy >= 0) begin
                    vx = vx + dx; vy = vy - dy; z = z + atan_step(i);
                end else begin
                    vx = vx - dx; vy = vy + dy; z = z - atan_step(i);
                end
            end
            return (z < 0) ? 0 : z;
        endfunction

        // doubled segment integral at 0 <= m <= chord half-width
        function wide_t seg_twice(longint unsigned m, longint unsigned h, wide_t r2);
            longint unsigned q, ang;
            wide_t t, hm;
            if (m == 0) return '0;
            q   = isqrt(sub_floor0(r2, wide_t'(m) * wide_t'(m)));
            ang = angle_of(m, q);
            t   = wide_t'(m) * wide_t'(q)
                + ((r2 * wide_t'(ang)) >> croa_pkg::ANG_FRAC);
            hm  = wide_t'(h) * wide_t'(m);
            return sub_floor0(t, hm + hm);
        endfunction

        // area between x = a..b above height h inside the circle
        function wide_t strip_area(longint a, longint b, longint h, longint unsigned r);
            wide_t r2, d;
            longint s;
            if (r == 0 || longint'(h) >= longint'(r)) return '0;
            r2 = wide_t'(r) * wide_t'(r);
            s  = isqrt(sub_floor0(r2, wide_t'(h) * wide_t'(h)));
            if (a < -s) a = -s;
            if (a > s)  a = s;
            if (b < -s) b = -s;
            if (b > s)  b = s;
            if (a >= 0)
                d = sub_floor0(seg_twice(b, h, r2), seg_twice(a, h, r2));
            else if (b <= 0)
                d = sub_floor0(seg_twice(-a, h, r2), seg_twice(-b, h, r2));
            else
                d = seg_twice(b, h, r2) + seg_twice(-a, h, r2);
            return d >> 1;
        endfunction

        function wide_t half_box(longint a, longint b, longint lo, longint hi,
                                 longint unsigned r);
            return sub_floor0(strip_area(a, b, lo, r), strip_area(a, b, hi, r));
        endfunction

        function logic [croa_pkg::AREA_W-1:0] predict_area(box_item_t it);
            longint x0, x1, y0, y1, t;
            longint unsigned r;
            wide_t area;
            x0 = longint'(it.x_a) - longint'(it.cx);
            x1 = longint'(it.x_b) - longint'(it.cx);
            y0 = longint'(it.y_a) - longint'(it.cy);
            y1 = longint'(it.y_b) - longint'(it.cy);
            r  = it.rad;
            if (x0 > x1) begin t = x0; x0 = x1; x1 = t; end
            if (y0 > y1) begin t = y0; y0 = y1; y1 = t; end
            if (y1 < 0)
                area = half_box(x0, x1, -y1, -y0, r);
            else if (y0 < 0)
                area = half_box(x0, x1, 0, -y0, r) + half_box(x0, x1, 0, y1, r);
            else
                area = half_box(x0, x1, y0, y1, r);
            return (area[127:64] != 0) ? '1 : area[63:0];
        endfunction

        function void note_input(box_item_t it);
            pending_area.push_back(predict_area(it));
        endfunction

        function void check_result(logic [croa_pkg::AREA_W-1:0] got);
            logic [croa_pkg::AREA_W-1:0] want;
            if (pending_area.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                errors++;
            end else begin
                want = pending_area.pop_front();
                if (got !== want) begin
                    $display("%0t: overlap_area mismatch, expected %h actual %h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic signed [croa_pkg::COORD_W-1:0]  s_left_edge = '0;
    logic signed [croa_pkg::COORD_W-1:0]  s_right_edge = '0;
    logic signed [croa_pkg::COORD_W-1:0]  s_bottom_edge = '0;
    logic signed [croa_pkg::COORD_W-1:0]  s_top_edge = '0;
    logic signed [croa_pkg::COORD_W-1:0]  s_centre_x = '0;
    logic signed [croa_pkg::COORD_W-1:0]  s_centre_y = '0;
    logic [croa_pkg::RADIUS_W-1:0]        s_radius = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic [croa_pkg::AREA_W-1:0]          m_overlap_area;

    area_scoreboard sb = new();
    int             tx_idle_pct = 0;
    int             rx_idle_pct = 0;

    circle_rect_overlap_area u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_edge    (s_left_edge),
        .s_right_edge   (s_right_edge),
        .s_bottom_edge  (s_bottom_edge),
        .s_top_edge     (s_top_edge),
        .s_centre_x     (s_centre_x),
        .s_centre_y     (s_centre_y),
        .s_radius       (s_radius),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_overlap_area (m_overlap_area)
    );

    // clock, 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // result transfers
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_overlap_area);
    end

    // one input transfer, with random sender gaps beforehand
    task automatic send_box(box_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_left_edge   <= it.x_a;
        s_right_edge  <= it.x_b;
        s_bottom_edge <= it.y_a;
        s_top_edge    <= it.y_b;
        s_centre_x    <= it.cx;
        s_centre_y    <= it.cy;
        s_radius      <= it.rad;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(it);
    endtask

    task automatic send_fields(longint xa, longint xb, longint ya, longint yb,
                               longint cx, longint cy, longint r);
        box_item_t it;
        it.x_a = croa_pkg::COORD_W'(xa);
        it.x_b = croa_pkg::COORD_W'(xb);
        it.y_a = croa_pkg::COORD_W'(ya);
        it.y_b = croa_pkg::COORD_W'(yb);
        it.cx  = croa_pkg::COORD_W'(cx);
        it.cy  = croa_pkg::COORD_W'(cy);
        it.rad = croa_pkg::RADIUS_W'(r);
        send_box(it);
    endtask

    // mostly boxes near the circle, some fully random noise
    task automatic send_random();
        box_item_t it;
        longint r, cx, cy, span;
        if ($urandom_range(99) < 20) begin
            it.x_a = $urandom; it.x_b = $urandom; it.y_a = $urandom;
            it.y_b = $urandom; it.cx = $urandom; it.cy = $urandom;
            it.rad = croa_pkg::RADIUS_W'($urandom);
        end else begin
            case ($urandom_range(3))
                0: r = $urandom_range(1, 32'h0000_ffff);
                1: r = $urandom_range(32'h0001_0000, 32'h0100_0000);
                2: r = $urandom_range(32'h0100_0000, 32'h7fff_ffff);
                default: r = $urandom_range(0, 3);
            endcase
            cx   = $signed($urandom) >>> $urandom_range(1, 8);
            cy   = $signed($urandom) >>> $urandom_range(1, 8);
            span = 3 * r + 2;
            it.rad = croa_pkg::RADIUS_W'(r);
            it.cx  = croa_pkg::COORD_W'(cx);
            it.cy  = croa_pkg::COORD_W'(cy);
            it.x_a = croa_pkg::COORD_W'(cx + longint'($urandom_range(0, span)) - span / 2);
            it.x_b = croa_pkg::COORD_W'(cx + longint'($urandom_range(0, span)) - span / 2);
            it.y_a = croa_pkg::COORD_W'(cy + longint'($urandom_range(0, span)) - span / 2);
            it.y_b = croa_pkg::COORD_W'(cy + longint'($urandom_range(0, span)) - span / 2);
        end
        send_box(it);
    endtask

    initial begin
        localparam longint ONE  = 64'sd65536;
        localparam longint MINV = -64'sd2147483648;
        localparam longint MAXV = 64'sd2147483647;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero radius, inside, enclosing, edge orders, half planes
        send_fields(-ONE, ONE, -ONE, ONE, 0, 0, 0);
        send_fields(-ONE, ONE, -ONE, ONE, 0, 0, 10 * ONE);
        send_fields(-20 * ONE, 20 * ONE, -20 * ONE, 20 * ONE, 0, 0, 10 * ONE);
        send_fields(20 * ONE, -20 * ONE, 20 * ONE, -20 * ONE, ONE, -ONE, 10 * ONE);
        send_fields(-5 * ONE, 3 * ONE, ONE, 7 * ONE, 0, 0, 10 * ONE);
        send_fields(-5 * ONE, 3 * ONE, -7 * ONE, -ONE, 0, 0, 10 * ONE);
        send_fields(2 * ONE, 8 * ONE, -4 * ONE, 6 * ONE, 0, 0, 10 * ONE);
        send_fields(-8 * ONE, -2 * ONE, -4 * ONE, 6 * ONE, 0, 0, 10 * ONE);
        send_fields(-ONE, ONE, 10 * ONE, 12 * ONE, 0, 0, 10 * ONE);
        send_fields(-ONE, ONE, 12 * ONE, 15 * ONE, 0, 0, 10 * ONE);
        send_fields(11 * ONE, 15 * ONE, -ONE, ONE, 0, 0, 10 * ONE);
        send_fields(0, 0, -ONE, ONE, 0, 0, 10 * ONE);
        send_fields(-ONE, ONE, 0, 0, 0, 0, 10 * ONE);
        send_fields(MINV, MAXV, MINV, MAXV, 0, 0, MAXV);
        send_fields(MAXV, MINV, MAXV, MINV, MINV, MAXV, MAXV);
        send_fields(MINV, MAXV, MINV, MAXV, MAXV, MINV, MAXV);
        send_fields(MINV, MINV, MAXV, MAXV, 0, 0, MAXV);
        send_fields(MAXV, MAXV, MAXV, MAXV, MINV, MINV, MAXV);
        send_fields(0, 1, 0, 1, 0, 0, 1);
        send_fields(-1, 1, -1, 1, 0, 0, 1);
        send_fields(-3, 2, -1, 4, 1, -1, 2);
        send_fields(MINV, MAXV, MINV, MAXV, 0, 0, 1);
        send_fields(MINV, MAXV, MINV, MAXV, 0, 0, 0);

        // random, three idling phases
        tx_idle_pct = 37; rx_idle_pct = 78;
        repeat (134) send_random();
        tx_idle_pct = 78; rx_idle_pct = 37;
        repeat (133) send_random();
        tx_idle_pct = 0; rx_idle_pct = 0;
        repeat (133) send_random();
        s_valid <= 1'b0;

        while (sb.pending_area.size() != 0) @(posedge aclk);
        repeat (900) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_area.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
